>>> rtl/lzd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_pkg: shared types and constants
// Types and codes used by the bit-flag LZ77 decompressor modules.
// ----------------------------------------------------------------------------
package lzd_pkg;

    typedef enum logic [3:0] {
        PH_KIND  = 4'd0,
        PH_SEL   = 4'd1,
        PH_S1    = 4'd2,
        PH_S2    = 4'd3,
        PH_LIT   = 4'd4,
        PH_SDIST = 4'd5,
        PH_LB1   = 4'd6,
        PH_LB2   = 4'd7,
        PH_LB3   = 4'd8,
        PH_DONE  = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        CMD_LIT  = 2'd0,
        CMD_COPY = 2'd1,
        CMD_END  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_kind_t;

    // One command from the parser to the copy engine.
    typedef struct packed {
        cmd_kind_t  kind;
        logic       restart;
        logic [7:0] lit;
        logic [8:0] len;
        logic [13:0] distance;
    } cmd_t;

    localparam logic [15:0] LONG_BASE = 16'hE000;
    localparam logic [7:0]  LEN_MASK  = 8'h07;

endpackage

>>> rtl/lzd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_in_if / lzd_out_if: stream channels
// Valid/ready channels for compressed input and decompressed results.
// ----------------------------------------------------------------------------
interface lzd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_start;
    modport source (output valid, output in_byte, output stream_start, input ready);
    modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

interface lzd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  out_count;
    logic        run_last;
    logic        stream_done;
    modport source (output valid, output out_bytes, output out_count, output run_last,
                    output stream_done, input ready);
    modport sink   (input valid, input out_bytes, input out_count, input run_last,
                    input stream_done, output ready);
endinterface

>>> rtl/lzd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_ram: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/lzd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_parser: front end
// Takes compressed bytes, tracks flag words and emits one command per byte.
// ----------------------------------------------------------------------------
module lzd_parser (
    input  logic          clk,
    input  logic          rst_n,
    lzd_in_if.sink        in_ch,
    output lzd_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_ready
);
    import lzd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] flag_reg, flag_next;
    logic [4:0]  left_reg, left_next;
    logic        held_reg, held_next;
    logic [7:0]  hold_reg, hold_next;
    logic [8:0]  len_reg, len_next;
    logic [13:0] dist_reg, dist_next;
    cmd_t        cmd_next;

    logic        fire;
    phase_t      ph0;
    logic [4:0]  left0;
    logic [15:0] span;

    assign in_ch.ready = cmd_ready;
    assign cmd_valid   = in_ch.valid;
    assign fire        = in_ch.valid && cmd_ready;
    assign cmd         = cmd_next;

    // Byte step, then up to four flag bits are consumed (a kind needs at most four).
    always_comb
    begin
        ph0       = in_ch.stream_start ? PH_KIND : phase_reg;
        flag_next = in_ch.stream_start ? 16'd0 : flag_reg;
        left0     = in_ch.stream_start ? 5'd0 : left_reg;
        held_next = in_ch.stream_start ? 1'b0 : held_reg;
        hold_next = in_ch.stream_start ? 8'd0 : hold_reg;
        len_next  = in_ch.stream_start ? 9'd0 : len_reg;
        dist_next = in_ch.stream_start ? 14'd0 : dist_reg;
        phase_next = ph0;
        left_next  = left0;
        span       = '0;
        cmd_next.kind     = CMD_NONE;
        cmd_next.restart  = in_ch.stream_start;
        cmd_next.lit      = in_ch.in_byte;
        cmd_next.len      = '0;
        cmd_next.distance = '0;
        if (ph0 != PH_DONE)
        begin
            if (left0 == 5'd0)
            begin
                if (!held_next)
                begin
                    hold_next = in_ch.in_byte;
                    held_next = 1'b1;
                end
                else
                begin
                    flag_next = {in_ch.in_byte, hold_next};
                    left_next = 5'd16;
                    held_next = 1'b0;
                end
            end
            else
            begin
                case (ph0)
                    PH_LIT:
                    begin
                        cmd_next.kind = CMD_LIT;
                        phase_next = PH_KIND;
                    end
                    PH_SDIST:
                    begin
                        cmd_next.kind     = CMD_COPY;
                        cmd_next.len      = len_next;
                        cmd_next.distance = 14'd256 - {6'd0, in_ch.in_byte};
                        len_next = '0;
                        phase_next = PH_KIND;
                    end
                    PH_LB1:
                    begin
                        hold_next = in_ch.in_byte;
                        phase_next = PH_LB2;
                    end
                    PH_LB2:
                    begin
                        span = {3'd0, in_ch.in_byte[7:3], hold_next} | LONG_BASE;
                        dist_next = 14'((17'h10000 - {1'b0, span}));
                        len_next = {6'd0, in_ch.in_byte[2:0] & LEN_MASK[2:0]} + 9'd2;
                        if (in_ch.in_byte[2:0] == 3'd0)
                        begin
                            phase_next = PH_LB3;
                        end
                        else
                        begin
                            cmd_next.kind     = CMD_COPY;
                            cmd_next.len      = len_next;
                            cmd_next.distance = dist_next;
                            len_next = '0;
                            phase_next = PH_KIND;
                        end
                    end
                    PH_LB3:
                    begin
                        if (in_ch.in_byte == 8'd0)
                        begin
                            cmd_next.kind = CMD_END;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            if (in_ch.in_byte != 8'd1)
                            begin
                                cmd_next.kind     = CMD_COPY;
                                cmd_next.len      = {1'b0, in_ch.in_byte} + 9'd1;
                                cmd_next.distance = dist_next;
                            end
                            len_next = '0;
                            phase_next = PH_KIND;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                left_next = left0;
            end
            for (int i = 0; i < 4; i++)
            begin
                if (left_next != 5'd0 && phase_next != PH_DONE &&
                    (phase_next == PH_KIND || phase_next == PH_SEL ||
                     phase_next == PH_S1 || phase_next == PH_S2))
                begin
                    case (phase_next)
                        PH_KIND: phase_next = flag_next[0] ? PH_LIT : PH_SEL;
                        PH_SEL:  phase_next = flag_next[0] ? PH_LB1 : PH_S1;
                        PH_S1:
                        begin
                            len_next = {7'd0, flag_next[0], 1'b0};
                            phase_next = PH_S2;
                        end
                        default:
                        begin
                            len_next = (len_next | {8'd0, flag_next[0]}) + 9'd2;
                            phase_next = PH_SDIST;
                        end
                    endcase
                    flag_next = flag_next >> 1;
                    left_next = left_next - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KIND;
            flag_reg  <= '0;
            left_reg  <= '0;
            held_reg  <= 1'b0;
            hold_reg  <= '0;
            len_reg   <= '0;
            dist_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            left_reg  <= left_next;
            held_reg  <= held_next;
            hold_reg  <= hold_next;
            len_reg   <= len_next;
            dist_reg  <= dist_next;
        end
    end

    ap_done_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == PH_DONE && !in_ch.stream_start) |-> cmd_next.kind == CMD_NONE)
        else $error("command issued after end of stream");
    ap_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= 5'd16)
        else $error("flag count out of range");
    ap_end_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd_next.kind == CMD_END) |=> phase_reg == PH_DONE)
        else $error("end code did not stop parser");
endmodule

>>> rtl/lzd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_fifo: command queue
// Two-entry queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  lzd_pkg::cmd_t wr_data,
    input  logic          wr_valid,
    output logic          wr_ready,
    output lzd_pkg::cmd_t rd_data,
    output logic          rd_valid,
    input  logic          rd_ready
);
    import lzd_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    ap_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("queue count overflow");
    ap_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg)
        else $error("queue pointers inconsistent");
    ap_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count lost a push");
endmodule

>>> rtl/lzd_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_engine: back end
// Runs literal, copy and end commands byte by byte through the history RAM,
// takes no new command while a copy is busy, and packs the bytes into results.
// ----------------------------------------------------------------------------
module lzd_engine #(
    parameter int HISTORY_DEPTH    = 8192,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lzd_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    lzd_out_if.source     out_ch
);
    import lzd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(BYTES_PER_RESULT + 1);

    // Copy: issue read (step 1), data arrives (step 2) and is written back.
    logic           busy_reg, busy_next;
    logic           rdp_reg, rdp_next;
    logic [8:0]     left_reg, left_next;
    logic [AW-1:0]  wp_reg, wp_next;
    logic [13:0]    dist_reg, dist_next;
    logic [63:0]    acc_reg, acc_next;
    logic [CW-1:0]  acnt_reg, acnt_next;
    logic           ov_reg, ov_next;
    logic [63:0]    ob_reg, ob_next;
    logic [3:0]     oc_reg, oc_next;
    logic           ol_reg, ol_next, od_reg, od_next;

    logic           we;
    logic [7:0]     wdata, rdata;
    logic [AW-1:0]  raddr;
    logic           emit, emit_last, emit_done, out_free, take;

    lzd_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
        .clk(clk), .we(we), .waddr(wp_reg), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign out_free  = !ov_reg || out_ch.ready;
    assign raddr     = wp_reg - AW'(dist_reg);
    assign out_ch.valid       = ov_reg;
    assign out_ch.out_bytes   = ob_reg;
    assign out_ch.out_count   = oc_reg;
    assign out_ch.run_last    = ol_reg;
    assign out_ch.stream_done = od_reg;

    always_comb
    begin
        busy_next = busy_reg;
        rdp_next  = 1'b0;
        left_next = left_reg;
        wp_next   = wp_reg;
        dist_next = dist_reg;
        acc_next  = acc_reg;
        acnt_next = acnt_reg;
        we        = 1'b0;
        wdata     = rdata;
        emit      = 1'b0;
        emit_last = 1'b0;
        emit_done = 1'b0;
        take      = 1'b0;
        cmd_ready = 1'b0;
        if (busy_reg)
        begin
            if (rdp_reg)
            begin
                if (out_free)
                begin
                    we = 1'b1;
                    wp_next = wp_reg + AW'(1);
                    acc_next = acc_reg | (64'(rdata) << (8 * acnt_reg));
                    acnt_next = acnt_reg + CW'(1);
                    left_next = left_reg - 9'd1;
                    if (left_next == 9'd0)
                    begin
                        emit = 1'b1;
                        emit_last = 1'b1;
                        busy_next = 1'b0;
                    end
                    else if (acnt_next == CW'(BYTES_PER_RESULT))
                    begin
                        emit = 1'b1;
                    end
                end
                else
                begin
                    rdp_next = 1'b1;
                end
            end
            else
            begin
                rdp_next = 1'b1;
            end
        end
        else if (out_free)
        begin
            cmd_ready = 1'b1;
            take = cmd_valid;
            if (cmd_valid)
            begin
                if (cmd.restart)
                begin
                    wp_next = '0;
                end
                case (cmd.kind)
                    CMD_LIT:
                    begin
                        we = 1'b1;
                        wdata = cmd.lit;
                        wp_next = wp_next + AW'(1);
                        acc_next = 64'(cmd.lit);
                        acnt_next = CW'(1);
                        emit = 1'b1;
                        emit_last = 1'b1;
                    end
                    CMD_COPY:
                    begin
                        busy_next = 1'b1;
                        left_next = cmd.len;
                        dist_next = cmd.distance;
                        acc_next = '0;
                        acnt_next = '0;
                    end
                    CMD_END:
                    begin
                        acc_next = '0;
                        acnt_next = '0;
                        emit = 1'b1;
                        emit_last = 1'b1;
                        emit_done = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        ov_next = ov_reg && !out_ch.ready;
        ob_next = ob_reg;
        oc_next = oc_reg;
        ol_next = ol_reg;
        od_next = od_reg;
        if (emit)
        begin
            ov_next = 1'b1;
            ob_next = acc_next;
            oc_next = 4'(acnt_next);
            ol_next = emit_last;
            od_next = emit_done;
            acc_next = '0;
            acnt_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg   <= ob_next;
        oc_reg   <= oc_next;
        ol_reg   <= ol_next;
        od_reg   <= od_next;
        acc_reg  <= acc_next;
        dist_reg <= dist_next;
        left_reg <= left_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rdp_reg  <= 1'b0;
            wp_reg   <= '0;
            acnt_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            rdp_reg  <= rdp_next;
            wp_reg   <= wp_next;
            acnt_reg <= acnt_next;
            ov_reg   <= ov_next;
        end
    end

    ap_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !take)
        else $error("command taken during copy");
    ap_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        acnt_reg < CW'(BYTES_PER_RESULT))
        else $error("packing count overflow");
    ap_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && od_reg) |-> (ol_reg && oc_reg == 4'd0))
        else $error("end result malformed");
endmodule

>>> rtl/lz77_bitflag_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_bitflag_decompressor: top level
// A literal is held in the command queue and then in the output register.
// A copy holds the back end byte by byte, since each history read waits
// for the prior write. Throughput: one literal or flag byte per cycle
// while the command queue has room.
// Reset clears all control state; the history RAM is not cleared.
// ----------------------------------------------------------------------------
module lz77_bitflag_decompressor #(
    parameter int HISTORY_DEPTH    = 8192,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    lzd_in_if.sink    in_ch,
    lzd_out_if.source out_ch
);
    import lzd_pkg::*;

    cmd_t p_cmd, q_cmd;
    logic p_valid, p_ready, q_valid, q_ready;

    lzd_parser u_parser (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .cmd(p_cmd), .cmd_valid(p_valid), .cmd_ready(p_ready)
    );

    lzd_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_data(p_cmd), .wr_valid(p_valid), .wr_ready(p_ready),
        .rd_data(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready)
    );

    lzd_engine #(.HISTORY_DEPTH(HISTORY_DEPTH), .BYTES_PER_RESULT(BYTES_PER_RESULT)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready), .out_ch(out_ch)
    );
endmodule
